// ===== rtl/stk_pkg.sv =====
// ---------------------------------------------------------------------------
// stk_pkg
// shared constants, command codes and control structs of the sorted table
// nearest-neighbor search
// ---------------------------------------------------------------------------
package stk_pkg;

  localparam int DEF_MAX_ENTRIES   = 4096;
  localparam int DEF_MAX_NEIGHBORS = 64;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int LABEL_W  = 12;
  localparam int NCOUNT_W = 7;
  localparam int DIST_W   = 32;
  localparam int OLABEL_W = 13;
  localparam int ENTRY_W  = VALUE_W + LABEL_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic query;
    logic chk_first;
    logic chk_last;
    logic srch_issue;
    logic srch_cmp;
    logic emit;
    logic fill;
  } stk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic rd_gt_q;
    logic search_done;
    logic out_free;
    logic emit_last;
    logic emit_fill;
  } stk_stat_t;

endpackage

// ===== rtl/stk_ram.sv =====
// ---------------------------------------------------------------------------
// stk_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
module stk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/stk_ctrl.sv =====
// ---------------------------------------------------------------------------
// stk_ctrl
// sequencer: accepts transactions, steps the binary search and the
// outward walk, one table read at a time
// ---------------------------------------------------------------------------
module stk_ctrl import stk_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_stall,
  output stk_cmd_t         cmd,
  input  stk_stat_t        stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_LAST  = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_FILL  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_CLEAR:  cmd.clear = 1'b1;
            CMD_APPEND: cmd.append = 1'b1;
            CMD_QUERY: begin
              cmd.query = 1'b1;
              state_nxt = stat.count_zero ? S_WALK : S_FIRST;
            end
            default: ;
          endcase
        end
      end
      S_FIRST: begin
        cmd.chk_first = 1'b1;
        state_nxt     = stat.rd_gt_q ? S_WALK : S_LAST;
      end
      S_LAST: begin
        cmd.chk_last = 1'b1;
        state_nxt    = stat.rd_gt_q ? S_SRCH : S_WALK;
      end
      S_SRCH: begin
        cmd.srch_issue = 1'b1;
        state_nxt      = stat.search_done ? S_WALK : S_CMP;
      end
      S_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_WALK: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_nxt = S_IDLE;
          end else if (stat.emit_fill) begin
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = S_WALK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded into a busy output register");

  a_fill_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> ($past(state_r) == S_WALK))
    else $error("refill without a preceding emit");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && stat.emit_last) |=> (state_r == S_IDLE))
    else $error("query did not end after its last result");

endmodule

// ===== rtl/stk_dp.sv =====
// ---------------------------------------------------------------------------
// stk_dp
// datapath: entry table, search bounds, cached left and right neighbors,
// distance compare and the output register
// ---------------------------------------------------------------------------
module stk_dp import stk_pkg::*; #(
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stk_cmd_t                   cmd,
  output stk_stat_t                  stat,
  input  logic signed [VALUE_W-1:0]  in_item_value,
  input  logic [LABEL_W-1:0]         in_entry_label,
  input  logic [NCOUNT_W-1:0]        in_neighbor_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DIST_W-1:0]          out_distance,
  output logic signed [OLABEL_W-1:0] out_label,
  output logic                       out_found,
  output logic                       out_last
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  function automatic logic [DIST_W-1:0] clamp_dist(input logic signed [VALUE_W:0] d);
    clamp_dist = d[VALUE_W] ? '0 : d[DIST_W-1:0];
  endfunction

  logic [CW-1:0]               count_r;
  logic signed [VALUE_W-1:0]   q_r;
  logic [NCOUNT_W-1:0]         k_r;
  logic [NCOUNT_W-1:0]         emit_cnt_r;
  logic [CW-1:0]               i0_r;
  logic [CW-1:0]               i1_r;
  logic [CW-1:0]               mid_r;
  logic                        left_ok_r;
  logic                        right_ok_r;
  logic                        fill_left_r;
  logic signed [VALUE_W-1:0]   lval_r;
  logic [LABEL_W-1:0]          llab_r;
  logic signed [VALUE_W-1:0]   rval_r;
  logic [LABEL_W-1:0]          rlab_r;

  logic                        out_valid_r;
  logic [DIST_W-1:0]           out_distance_r;
  logic signed [OLABEL_W-1:0]  out_label_r;
  logic                        out_found_r;
  logic                        out_last_r;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [ENTRY_W-1:0]          rd_data;
  logic signed [VALUE_W-1:0]   rd_val;
  logic [LABEL_W-1:0]          rd_lab;
  logic                        wr_en;

  logic [CW:0]                 bound_sum;
  logic [CW-1:0]               mid;
  logic [CW-1:0]               i0_dec;
  logic [CW-1:0]               i1_inc;
  logic [NCOUNT_W-1:0]         k_clamped;

  logic signed [VALUE_W:0]     q_x;
  logic signed [VALUE_W:0]     l_x;
  logic signed [VALUE_W:0]     r_x;
  logic signed [VALUE_W:0]     dl;
  logic signed [VALUE_W:0]     dr;
  logic                        take_left;
  logic                        any_found;
  logic                        emit_fill;
  logic                        emit_last;

  assign rd_val = rd_data[ENTRY_W-1:LABEL_W];
  assign rd_lab = rd_data[LABEL_W-1:0];

  assign bound_sum = {1'b0, i0_r} + {1'b0, i1_r};
  assign mid       = bound_sum[CW:1];
  assign i0_dec    = i0_r - CW'(1);
  assign i1_inc    = i1_r + CW'(1);

  // distances kept one bit wider so the compare is exact
  assign q_x = {q_r[VALUE_W-1], q_r};
  assign l_x = {lval_r[VALUE_W-1], lval_r};
  assign r_x = {rval_r[VALUE_W-1], rval_r};
  assign dl  = q_x - l_x;
  assign dr  = r_x - q_x;

  // ties go right
  assign take_left = left_ok_r && (!right_ok_r || (dl < dr));
  assign any_found = left_ok_r || right_ok_r;
  assign emit_fill = take_left ? (i0_r != '0) : (right_ok_r && (i1_inc < count_r));
  assign emit_last = (emit_cnt_r == (k_r - NCOUNT_W'(1)));

  always_comb begin
    if (in_neighbor_count == '0) begin
      k_clamped = NCOUNT_W'(1);
    end else if (in_neighbor_count > NCOUNT_W'(MAX_NEIGHBORS)) begin
      k_clamped = NCOUNT_W'(MAX_NEIGHBORS);
    end else begin
      k_clamped = in_neighbor_count;
    end
  end

  // table read address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.query) begin
      rd_en = 1'b1;
    end else if (cmd.chk_first) begin
      rd_en   = 1'b1;
      rd_addr = AW'(count_r - CW'(1));
    end else if (cmd.srch_issue) begin
      rd_en   = 1'b1;
      rd_addr = mid[AW-1:0];
    end else if (cmd.emit && emit_fill) begin
      rd_en   = 1'b1;
      rd_addr = take_left ? i0_dec[AW-1:0] : i1_inc[AW-1:0];
    end
  end

  assign wr_en = cmd.append && (count_r < CW'(MAX_ENTRIES));

  stk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({in_item_value, in_entry_label}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      left_ok_r   <= 1'b0;
      right_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + CW'(1);
      end

      if (cmd.query) begin
        left_ok_r  <= 1'b0;
        right_ok_r <= 1'b0;
      end else if (cmd.chk_first) begin
        right_ok_r <= stat.rd_gt_q;
      end else if (cmd.chk_last) begin
        left_ok_r  <= 1'b1;
        right_ok_r <= stat.rd_gt_q;
      end else if (cmd.emit) begin
        if (take_left) begin
          left_ok_r <= (i0_r != '0);
        end else if (right_ok_r) begin
          right_ok_r <= (i1_inc < count_r);
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      q_r        <= in_item_value;
      k_r        <= k_clamped;
      emit_cnt_r <= '0;
    end

    if (cmd.chk_first) begin
      lval_r <= rd_val;
      llab_r <= rd_lab;
      rval_r <= rd_val;
      rlab_r <= rd_lab;
      i0_r   <= '0;
      i1_r   <= '0;
    end

    if (cmd.chk_last) begin
      if (stat.rd_gt_q) begin
        rval_r <= rd_val;
        rlab_r <= rd_lab;
        i0_r   <= '0;
        i1_r   <= count_r;
      end else begin
        lval_r <= rd_val;
        llab_r <= rd_lab;
        i0_r   <= count_r - CW'(1);
      end
    end

    if (cmd.srch_issue) begin
      mid_r <= mid;
    end

    if (cmd.srch_cmp) begin
      if (stat.rd_gt_q) begin
        i1_r   <= mid_r;
        rval_r <= rd_val;
        rlab_r <= rd_lab;
      end else begin
        i0_r   <= mid_r;
        lval_r <= rd_val;
        llab_r <= rd_lab;
      end
    end

    if (cmd.emit) begin
      emit_cnt_r  <= emit_cnt_r + NCOUNT_W'(1);
      fill_left_r <= take_left;
      out_last_r  <= emit_last;
      out_found_r <= any_found;
      if (take_left) begin
        out_distance_r <= clamp_dist(dl);
        out_label_r    <= {1'b0, llab_r};
        if (i0_r != '0) begin
          i0_r <= i0_dec;
        end
      end else if (right_ok_r) begin
        out_distance_r <= clamp_dist(dr);
        out_label_r    <= {1'b0, rlab_r};
        i1_r           <= i1_inc;
      end else begin
        out_distance_r <= '1;
        out_label_r    <= '1;
      end
    end

    if (cmd.fill) begin
      if (fill_left_r) begin
        lval_r <= rd_val;
        llab_r <= rd_lab;
      end else begin
        rval_r <= rd_val;
        rlab_r <= rd_lab;
      end
    end
  end

  assign stat.count_zero  = (count_r == '0);
  assign stat.rd_gt_q     = (rd_val > q_r);
  assign stat.search_done = (({1'b0, i0_r} + (CW+1)'(1)) >= {1'b0, i1_r});
  assign stat.out_free    = !out_valid_r || !out_stall;
  assign stat.emit_last   = emit_last;
  assign stat.emit_fill   = emit_fill;

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_label    = out_label_r;
  assign out_found    = out_found_r;
  assign out_last     = out_last_r;

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (left_ok_r && right_ok_r) |-> (i0_r < i1_r))
    else $error("left bound not below right bound");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

endmodule

// ===== rtl/sorted_table_knn_1d.sv =====
// ---------------------------------------------------------------------------
// sorted_table_knn_1d
// one-dimensional k-nearest-neighbor search over a host-sorted table
// ---------------------------------------------------------------------------
// The block keeps up to MAX_ENTRIES signed Q16.16 values, appended by the
// host in ascending order, each with its 12-bit label. A clear or an append
// transaction is taken while the sequencer stays idle. A query is accepted,
// then two reads check the ends of the table, then each binary search step
// issues a read and compares its data, then each neighbor is emitted once
// the output register is free, a neighbor that needs a table refill being
// followed by a refill step and the last one never refilling. The pace is
// set by the single read port of the entry table, whose read data is
// registered: each search step and each refill is one read plus its use.
// No new transaction is taken while a query runs; results wait in an output
// register so the next transaction is taken while the last result is held.
// Results come in order of distance, ties going to the right-hand entry;
// missing neighbors give found = 0, label -1 and the saturated distance.
// ---------------------------------------------------------------------------
module sorted_table_knn_1d import stk_pkg::*; #(
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input transactions
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic signed [VALUE_W-1:0]  in_item_value,
  input  logic [LABEL_W-1:0]         in_entry_label,
  input  logic [NCOUNT_W-1:0]        in_neighbor_count,
  // result transactions
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DIST_W-1:0]          out_distance,
  output logic signed [OLABEL_W-1:0] out_label,
  output logic                       out_found,
  output logic                       out_last
);

  // command and status between sequencer and datapath
  stk_cmd_t  cmd;
  stk_stat_t stat;

  // sequencer: owns the input handshake and the query steps
  stk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: table memory, search bounds, neighbor cache, output register
  stk_dp #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_item_value     (in_item_value),
    .in_entry_label    (in_entry_label),
    .in_neighbor_count (in_neighbor_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_distance      (out_distance),
    .out_label         (out_label),
    .out_found         (out_found),
    .out_last          (out_last)
  );

endmodule
